### rtl/staircase_swipe_light_controller_top_assert.svh
// Assertion macros shared by the checker of the staircase swipe light controller.
`ifndef STAIRCASE_SWIPE_LIGHT_CONTROLLER_TOP_ASSERT_SVH
`define STAIRCASE_SWIPE_LIGHT_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SSLC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define SSLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sslc_pkg.sv
// Package of the staircase swipe light controller: widths, codes, types and helpers.
`timescale 1ns / 1ps
`default_nettype none
package sslc_pkg;

  localparam int unsigned MaxSegments    = 32;
  localparam int unsigned ScanIntervalMs = 250;

  localparam int unsigned SegW     = $clog2(MaxSegments + 1);
  localparam int unsigned FirstW   = 5;
  localparam int unsigned EndW     = 6;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned RangeW   = 16;
  localparam int unsigned LimitW   = 11;
  localparam int unsigned StepW    = 14;
  localparam int unsigned HoldW    = 20;
  localparam int unsigned MaskW    = 32;
  localparam int unsigned LitW     = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [StepW-1:0]  StepDelayRst = StepW'(150);
  localparam logic [HoldW-1:0]  HoldTimeRst  = HoldW'(30000);
  localparam logic [LimitW-1:0] LimitRst     = LimitW'(900);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgActive      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgStepDelay   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgHoldTime    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgBottomLimit = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgTopLimit    = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgPowerFollow = CfgIdxW'(5);

  typedef struct packed {
    logic              active;
    logic [StepW-1:0]  step_delay_ms;
    logic [HoldW-1:0]  hold_time_ms;
    logic [LimitW-1:0] bottom_limit_mm;
    logic [LimitW-1:0] top_limit_mm;
    logic              power_follow;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic [RangeW-1:0] bottom_range_mm;
    logic [RangeW-1:0] top_range_mm;
    logic              range_timeout;
    logic              force_bottom;
    logic              force_top;
    logic [FirstW-1:0] first_segment;
    logic [EndW-1:0]   segment_end;
    logic              lights_off;
  } in_item_t;

  typedef struct packed {
    logic [LitW-1:0]  lit_first;
    logic [LitW-1:0]  lit_end;
    logic [MaskW-1:0] lit_mask;
    logic             refresh;
    logic             power_toggle;
    logic             bottom_occupied;
    logic             top_occupied;
    logic             bottom_changed;
    logic             top_changed;
  } out_item_t;

  typedef struct packed {
    logic             running;
    logic             going_up;
    logic             last_from_top;
    logic             primed;
    logic [SegW-1:0]  window_start;
    logic [SegW-1:0]  window_end;
    logic [TimeW-1:0] last_step_ms;
    logic [TimeW-1:0] last_scan_ms;
    logic [TimeW-1:0] last_trigger_ms;
    logic             bottom_state;
    logic             top_state;
    logic             bottom_force_pending;
    logic             top_force_pending;
  } state_t;

  // State after reset or after a write of the enable register.
  function automatic state_t state_clear();
    state_t s;
    s          = '0;
    s.going_up = 1'b1;
    return s;
  endfunction

endpackage
`default_nettype wire

### rtl/sslc_if.sv
// Handshake channel interfaces of the staircase swipe light controller.
`timescale 1ns / 1ps
`default_nettype none
interface sslc_in_if;
  logic                             valid;
  logic                             ready;
  logic [sslc_pkg::TimeW-1:0]       now_ms;
  logic [sslc_pkg::RangeW-1:0]      bottom_range_mm;
  logic [sslc_pkg::RangeW-1:0]      top_range_mm;
  logic                             range_timeout;
  logic                             force_bottom;
  logic                             force_top;
  logic [sslc_pkg::FirstW-1:0]      first_segment;
  logic [sslc_pkg::EndW-1:0]        segment_end;
  logic                             lights_off;

  modport source (
    output valid, now_ms, bottom_range_mm, top_range_mm, range_timeout,
           force_bottom, force_top, first_segment, segment_end, lights_off,
    input  ready
  );
  modport sink (
    input  valid, now_ms, bottom_range_mm, top_range_mm, range_timeout,
           force_bottom, force_top, first_segment, segment_end, lights_off,
    output ready
  );
endinterface

interface sslc_out_if;
  logic                        valid;
  logic                        ready;
  logic [sslc_pkg::LitW-1:0]   lit_first;
  logic [sslc_pkg::LitW-1:0]   lit_end;
  logic [sslc_pkg::MaskW-1:0]  lit_mask;
  logic                        refresh;
  logic                        power_toggle;
  logic                        bottom_occupied;
  logic                        top_occupied;
  logic                        bottom_changed;
  logic                        top_changed;

  modport source (
    output valid, lit_first, lit_end, lit_mask, refresh, power_toggle,
           bottom_occupied, top_occupied, bottom_changed, top_changed,
    input  ready
  );
  modport sink (
    input  valid, lit_first, lit_end, lit_mask, refresh, power_toggle,
           bottom_occupied, top_occupied, bottom_changed, top_changed,
    output ready
  );
endinterface

interface sslc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sslc_pkg::CfgIdxW-1:0]  index;
  logic [sslc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/sslc_cfg.sv
// Configuration register file of the staircase swipe light controller.
`timescale 1ns / 1ps
`default_nettype none
module sslc_cfg (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            wr_en_i,
  input  wire [sslc_pkg::CfgIdxW-1:0]    wr_index_i,
  input  wire [sslc_pkg::CfgDataW-1:0]   wr_data_i,
  output sslc_pkg::cfg_t                 cfg_o,
  output logic                           clear_o
);

  sslc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d   = cfg_q;
    clear_o = 1'b0;
    if (wr_en_i) begin
      case (wr_index_i)
        sslc_pkg::CfgActive: begin
          cfg_d.active = wr_data_i[0];
          clear_o      = 1'b1;
        end
        sslc_pkg::CfgStepDelay: begin
          cfg_d.step_delay_ms = wr_data_i[sslc_pkg::StepW-1:0];
        end
        sslc_pkg::CfgHoldTime: begin
          cfg_d.hold_time_ms = wr_data_i[sslc_pkg::HoldW-1:0];
        end
        sslc_pkg::CfgBottomLimit: begin
          cfg_d.bottom_limit_mm = wr_data_i[sslc_pkg::LimitW-1:0];
        end
        sslc_pkg::CfgTopLimit: begin
          cfg_d.top_limit_mm = wr_data_i[sslc_pkg::LimitW-1:0];
        end
        sslc_pkg::CfgPowerFollow: begin
          cfg_d.power_follow = wr_data_i[0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active          <= 1'b0;
      cfg_q.step_delay_ms   <= sslc_pkg::StepDelayRst;
      cfg_q.hold_time_ms    <= sslc_pkg::HoldTimeRst;
      cfg_q.bottom_limit_mm <= sslc_pkg::LimitRst;
      cfg_q.top_limit_mm    <= sslc_pkg::LimitRst;
      cfg_q.power_follow    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### rtl/sslc_pass.sv
// One control loop pass: scan, swipe start, run-out, window step and lit mask.
`timescale 1ns / 1ps
`default_nettype none
module sslc_pass #(
  parameter int unsigned ScanIntervalMs = sslc_pkg::ScanIntervalMs
) (
  input  sslc_pkg::cfg_t      cfg_i,
  input  sslc_pkg::state_t    state_i,
  input  sslc_pkg::in_item_t  item_i,
  output sslc_pkg::state_t    state_o,
  output sslc_pkg::out_item_t res_o
);

  localparam int unsigned SegW = sslc_pkg::SegW;
  localparam int unsigned TimeW = sslc_pkg::TimeW;
  localparam logic [SegW-1:0] SegMax = SegW'(sslc_pkg::MaxSegments);

  sslc_pkg::state_t     s;
  logic [SegW-1:0]      lo, hi, os, oe;
  logic [SegW:0]        end_inc, start_inc, lo_inc, start_inc2;
  logic [TimeW-1:0]     scan_el, trig_el, step_el;
  logic                 b, t, bch, tch, toggle, refresh, empty;
  logic [sslc_pkg::MaskW-1:0] mask;

  always_comb begin
    s       = state_i;
    bch     = 1'b0;
    tch     = 1'b0;
    toggle  = 1'b0;
    refresh = 1'b0;
    b       = 1'b0;
    t       = 1'b0;
    empty   = 1'b0;
    os      = '0;
    oe      = '0;
    end_inc = '0;
    start_inc  = '0;
    lo_inc     = '0;
    start_inc2 = '0;

    // Span bounds, clamped to the strip length.
    lo = (SegW'(item_i.first_segment) > SegMax) ? SegMax : SegW'(item_i.first_segment);
    hi = (SegW'(item_i.segment_end) > SegMax) ? SegMax : SegW'(item_i.segment_end);

    if (item_i.force_bottom) s.bottom_force_pending = 1'b1;
    if (item_i.force_top)    s.top_force_pending    = 1'b1;

    scan_el = item_i.now_ms - state_i.last_scan_ms;

    if (cfg_i.active) begin
      if (!s.primed) begin
        s.window_start = lo;
        s.window_end   = hi;
        s.primed       = 1'b1;
      end

      if (scan_el >= TimeW'(ScanIntervalMs)) begin
        s.last_scan_ms = item_i.now_ms;
        if (!item_i.range_timeout) begin
          b = s.bottom_force_pending ||
              (item_i.bottom_range_mm < sslc_pkg::RangeW'(cfg_i.bottom_limit_mm));
          t = s.top_force_pending ||
              (item_i.top_range_mm < sslc_pkg::RangeW'(cfg_i.top_limit_mm));
          bch = (b != s.bottom_state);
          tch = (t != s.top_state);
          s.bottom_state         = b;
          s.top_state            = t;
          s.bottom_force_pending = 1'b0;
          s.top_force_pending    = 1'b0;
          if (b != t) begin
            s.last_trigger_ms = item_i.now_ms;
            if (s.running) begin
              s.last_from_top = t;
            end else begin
              empty      = (s.window_start == s.window_end);
              toggle     = cfg_i.power_follow && empty && item_i.lights_off;
              s.going_up = b;
              if (empty) begin
                s.window_start = b ? lo : hi;
                s.window_end   = s.window_start;
              end
              s.running = 1'b1;
            end
          end
        end
      end

      // Run-out once the hold time has passed with both sensors clear.
      trig_el = item_i.now_ms - s.last_trigger_ms;
      if (s.running && (trig_el > TimeW'(cfg_i.hold_time_ms)) &&
          !s.bottom_state && !s.top_state) begin
        s.going_up = s.last_from_top;
        s.running  = 1'b0;
      end

      step_el = item_i.now_ms - s.last_step_ms;
      if (step_el > TimeW'(cfg_i.step_delay_ms)) begin
        os             = s.window_start;
        oe             = s.window_end;
        s.last_step_ms = item_i.now_ms;
        end_inc    = {1'b0, oe} + 1'b1;
        start_inc  = {1'b0, os} + 1'b1;
        lo_inc     = {1'b0, lo} + 1'b1;
        start_inc2 = start_inc;
        if (s.running) begin
          if (s.going_up) begin
            s.window_end = (end_inc < {1'b0, hi}) ? end_inc[SegW-1:0] : hi;
          end else begin
            s.window_start = ({1'b0, os} > lo_inc) ? (os - 1'b1) : lo;
          end
        end else begin
          if (s.going_up) begin
            s.window_start = (start_inc < {1'b0, oe}) ? start_inc[SegW-1:0] : oe;
          end else begin
            s.window_end = ({1'b0, oe} > start_inc2) ? (oe - 1'b1) : os;
          end
        end
        if ((os != s.window_start) || (oe != s.window_end)) begin
          refresh = 1'b1;
          if (cfg_i.power_follow && (s.window_start == s.window_end) &&
              !item_i.lights_off && !s.running) begin
            toggle = 1'b1;
          end
        end
      end
    end else begin
      trig_el = '0;
      step_el = '0;
    end
  end

  // Each mask bit is an independent span and window test.
  always_comb begin
    for (int i = 0; i < sslc_pkg::MaskW; i++) begin
      mask[i] = (i >= int'(lo)) && (i < int'(hi)) &&
                (i >= int'(s.window_start)) && (i < int'(s.window_end));
    end
  end

  always_comb begin
    state_o               = s;
    res_o.lit_first       = sslc_pkg::LitW'(s.window_start);
    res_o.lit_end         = sslc_pkg::LitW'(s.window_end);
    res_o.lit_mask        = mask;
    res_o.refresh         = refresh;
    res_o.power_toggle    = toggle;
    res_o.bottom_occupied = s.bottom_state;
    res_o.top_occupied    = s.top_state;
    res_o.bottom_changed  = bch;
    res_o.top_changed     = tch;
  end

endmodule
`default_nettype wire

### rtl/staircase_swipe_light_controller_top.sv
// Path: an accepted beat passes the input register, then the result register on res_o.
// Throughput: one beat per cycle while the sink keeps up; the pass logic between the
// input and result registers closes the loop on the controller state combinationally.
// Reset: rst_ni clears the state and both stage valids and resets the configuration;
// a write of the enable register clears the controller state in the cycle it lands.
`timescale 1ns / 1ps
`default_nettype none
module staircase_swipe_light_controller_top #(
  parameter int unsigned ScanIntervalMs = sslc_pkg::ScanIntervalMs
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  sslc_cfg_if.sink   cfg_i,
  sslc_in_if.sink    in_i,
  sslc_out_if.source res_o
);

  // Configuration registers. The port never stalls; the enable register also
  // issues a clear of the controller state.
  sslc_pkg::cfg_t cfg;
  logic           cfg_clear;

  assign cfg_i.ready = 1'b1;

  sslc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg),
    .clear_o    (cfg_clear)
  );

  // Two register stages: the input register holds the accepted beat, the
  // result register holds the finished one until the sink takes it. A beat
  // moves on whenever the result register is empty or being emptied, so an
  // empty input register can still take one beat while a result waits; with
  // both registers full the input stalls until the sink takes the result.
  logic                 in_vld_q;
  sslc_pkg::in_item_t   in_item_q;
  logic                 out_vld_q;
  sslc_pkg::out_item_t  out_item_q;
  sslc_pkg::state_t     state_q, state_d;
  sslc_pkg::out_item_t  res_d;
  sslc_pkg::in_item_t   in_item;
  logic                 out_free, fire;

  assign out_free   = !out_vld_q || res_o.ready;
  assign fire       = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;

  always_comb begin
    in_item.now_ms          = in_i.now_ms;
    in_item.bottom_range_mm = in_i.bottom_range_mm;
    in_item.top_range_mm    = in_i.top_range_mm;
    in_item.range_timeout   = in_i.range_timeout;
    in_item.force_bottom    = in_i.force_bottom;
    in_item.force_top       = in_i.force_top;
    in_item.first_segment   = in_i.first_segment;
    in_item.segment_end     = in_i.segment_end;
    in_item.lights_off      = in_i.lights_off;
  end

  // The whole pass is evaluated against the registered controller state, and
  // the updated state is written back in the same cycle as the result.
  sslc_pass #(
    .ScanIntervalMs (ScanIntervalMs)
  ) u_pass (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (in_item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= sslc_pkg::state_clear();
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_clear) begin
        state_q <= sslc_pkg::state_clear();
      end else if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_item;
    end
    if (fire) begin
      out_item_q <= res_d;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.lit_first       = out_item_q.lit_first;
  assign res_o.lit_end         = out_item_q.lit_end;
  assign res_o.lit_mask        = out_item_q.lit_mask;
  assign res_o.refresh         = out_item_q.refresh;
  assign res_o.power_toggle    = out_item_q.power_toggle;
  assign res_o.bottom_occupied = out_item_q.bottom_occupied;
  assign res_o.top_occupied    = out_item_q.top_occupied;
  assign res_o.bottom_changed  = out_item_q.bottom_changed;
  assign res_o.top_changed     = out_item_q.top_changed;

endmodule
`default_nettype wire

### rtl/sslc_checker.sv
// Port-level checker of the staircase swipe light controller and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "staircase_swipe_light_controller_top_assert.svh"
module sslc_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           res_valid_i,
  input wire                           res_ready_i,
  input wire [sslc_pkg::LitW-1:0]      lit_first_i,
  input wire [sslc_pkg::LitW-1:0]      lit_end_i,
  input wire [sslc_pkg::MaskW-1:0]     lit_mask_i,
  input wire                           refresh_i,
  input wire                           power_toggle_i,
  input wire                           bottom_changed_i,
  input wire                           top_changed_i
);

  `SSLC_ASSERT_NEXT(a_res_held, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i, "result beat dropped while stalled")

  `SSLC_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, res_valid_i && !res_ready_i, $stable(lit_mask_i) && $stable(lit_first_i) && $stable(lit_end_i), "stalled result changed")

  // A power request only ever comes with a sensor change or a window step.
  `SSLC_ASSERT_NOW(a_toggle_cause, clk_i, rst_ni, res_valid_i && power_toggle_i, refresh_i || bottom_changed_i || top_changed_i, "power request without a cause")

  // An empty window lights nothing.
  `SSLC_ASSERT_NOW(a_empty_dark, clk_i, rst_ni, res_valid_i && (lit_first_i == lit_end_i), lit_mask_i == '0, "empty window with lit segments")

endmodule

bind staircase_swipe_light_controller_top sslc_checker u_sslc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .lit_first_i      (res_o.lit_first),
  .lit_end_i        (res_o.lit_end),
  .lit_mask_i       (res_o.lit_mask),
  .refresh_i        (res_o.refresh),
  .power_toggle_i   (res_o.power_toggle),
  .bottom_changed_i (res_o.bottom_changed),
  .top_changed_i    (res_o.top_changed)
);
`default_nettype wire

### tb/tb_staircase_swipe_light_controller_top.sv
// Self-checking testbench of the staircase swipe light controller against a cycle-free predictor.
`timescale 1ns / 1ps
module tb_staircase_swipe_light_controller_top;
  import sslc_pkg::*;

  // One line of the directed script: either a register write or a pass beat. A pass beat
  // may carry a hand-written expectation; otherwise the predictor supplies it.
  typedef struct {
    bit                    is_reg;
    logic [CfgIdxW-1:0]    reg_idx;
    logic [CfgDataW-1:0]   reg_val;
    in_item_t              pass;
    bit                    typed;
    out_item_t             want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  sslc_cfg_if cfg_bus ();
  sslc_in_if  in_bus ();
  sslc_out_if res_bus ();

  staircase_swipe_light_controller_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .res_o  (res_bus)
  );

  // Shadow copy of the configuration registers, updated when a write beat lands.
  logic              cf_active;
  logic [StepW-1:0]  cf_step;
  logic [HoldW-1:0]  cf_hold;
  logic [LimitW-1:0] cf_blim;
  logic [LimitW-1:0] cf_tlim;
  logic              cf_pfollow;

  // Shadow copy of the controller state.
  logic        running, going_up, from_top, primed;
  int unsigned win_start, win_end;
  logic [31:0] last_step, last_scan, last_trigger;
  logic        bot_occ, top_occ, bot_force, top_force;

  // Lit windows still to come out of the block, oldest first.
  out_item_t awaited_windows[$];
  int        mismatches = 0;

  // Side-band of the beat on the input channel: a hand-written expectation, if any.
  bit        row_typed = 1'b0;
  out_item_t row_want  = '0;

  // Stimulus state: the running millisecond clock, the staircase span of the current
  // phase, the master power as the stimulus believes it, and a stretch without stalls.
  logic [31:0] clock_ms = '0;
  int unsigned span_lo = 0;
  int unsigned span_hi = MaxSegments;
  bit          dark_now = 1'b0;
  bit          calm = 1'b0;
  int          beats_offered = 0;

  script_row_t script[$];

  task automatic clear_controller();
    running      = 1'b0;
    going_up     = 1'b1;
    from_top     = 1'b0;
    primed       = 1'b0;
    win_start    = 0;
    win_end      = 0;
    last_step    = '0;
    last_scan    = '0;
    last_trigger = '0;
    bot_occ      = 1'b0;
    top_occ      = 1'b0;
    bot_force    = 1'b0;
    top_force    = 1'b0;
  endtask

  task automatic apply_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      CfgActive: begin
        // Any write of the enable register throws away the runtime state.
        cf_active = val[0];
        clear_controller();
      end
      CfgStepDelay:   cf_step    = val[StepW-1:0];
      CfgHoldTime:    cf_hold    = val[HoldW-1:0];
      CfgBottomLimit: cf_blim    = val[LimitW-1:0];
      CfgTopLimit:    cf_tlim    = val[LimitW-1:0];
      CfgPowerFollow: cf_pfollow = val[0];
      default: ;
    endcase
  endtask

  // One loop pass of the controller: advances the shadow state and yields the window.
  task automatic step_stair_model(input in_item_t p, output out_item_t r);
    int unsigned lo, hi, os, oe, seg;
    logic [31:0] since, mask;
    logic        b, t, refresh, toggle, b_chg, t_chg;
    lo      = p.first_segment;
    hi      = (p.segment_end > MaxSegments) ? MaxSegments : p.segment_end;
    refresh = 1'b0;
    toggle  = 1'b0;
    b_chg   = 1'b0;
    t_chg   = 1'b0;
    mask    = '0;
    // Manual triggers latch even while the controller is disabled.
    if (p.force_bottom) bot_force = 1'b1;
    if (p.force_top) top_force = 1'b1;
    if (cf_active) begin
      if (!primed) begin
        win_start = lo;
        win_end   = hi;
        primed    = 1'b1;
      end
      since = p.now_ms - last_scan;
      if (since >= ScanIntervalMs) begin
        last_scan = p.now_ms;
        // A timed-out reading skips the scan but keeps the latched triggers.
        if (!p.range_timeout) begin
          b = bot_force || (p.bottom_range_mm < cf_blim);
          t = top_force || (p.top_range_mm < cf_tlim);
          if (b != bot_occ) begin
            bot_occ = b;
            b_chg   = 1'b1;
          end
          if (t != top_occ) begin
            top_occ = t;
            t_chg   = 1'b1;
          end
          bot_force = 1'b0;
          top_force = 1'b0;
          if (b != t) begin
            last_trigger = p.now_ms;
            if (running) begin
              from_top = t;
            end else begin
              if (cf_pfollow && win_start == win_end && p.lights_off) toggle = 1'b1;
              going_up = b;
              if (win_start == win_end) begin
                win_start = going_up ? lo : hi;
                win_end   = win_start;
              end
              running = 1'b1;
            end
          end
        end
      end
      since = p.now_ms - last_trigger;
      if (running && since > cf_hold && !bot_occ && !top_occ) begin
        going_up = from_top;
        running  = 1'b0;
      end
      since = p.now_ms - last_step;
      if (since > cf_step) begin
        os        = win_start;
        oe        = win_end;
        last_step = p.now_ms;
        if (running && going_up) begin
          win_end = (win_end + 1 < hi) ? win_end + 1 : hi;
        end else if (running) begin
          win_start = (win_start > lo + 1) ? win_start - 1 : lo;
        end else if (going_up) begin
          win_start = (win_start + 1 < win_end) ? win_start + 1 : win_end;
        end else begin
          win_end = (win_end > win_start + 1) ? win_end - 1 : win_start;
        end
        if (os != win_start || oe != win_end) begin
          refresh = 1'b1;
          if (cf_pfollow && win_start == win_end && !p.lights_off && !running) toggle = 1'b1;
        end
      end
    end
    for (seg = 0; seg < 32; seg++) begin
      if (seg >= lo && seg < hi && seg >= win_start && seg < win_end) mask[seg] = 1'b1;
    end
    r.lit_first       = LitW'(win_start);
    r.lit_end         = LitW'(win_end);
    r.lit_mask        = mask;
    r.refresh         = refresh;
    r.power_toggle    = toggle;
    r.bottom_occupied = bot_occ;
    r.top_occupied    = top_occ;
    r.bottom_changed  = b_chg;
    r.top_changed     = t_chg;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Everything that crosses a channel is sampled here, on the rising edge, so the predictor
  // sees register writes and passes in exactly the order that the block accepts them.
  always @(posedge clk_i) begin
    in_item_t  seen;
    out_item_t pred, got, want;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) apply_register(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) begin
        seen.now_ms          = in_bus.now_ms;
        seen.bottom_range_mm = in_bus.bottom_range_mm;
        seen.top_range_mm    = in_bus.top_range_mm;
        seen.range_timeout   = in_bus.range_timeout;
        seen.force_bottom    = in_bus.force_bottom;
        seen.force_top       = in_bus.force_top;
        seen.first_segment   = in_bus.first_segment;
        seen.segment_end     = in_bus.segment_end;
        seen.lights_off      = in_bus.lights_off;
        // The predictor always runs so that its state keeps pace, even when the
        // expectation for this beat was written by hand.
        step_stair_model(seen, pred);
        awaited_windows.push_back(row_typed ? row_want : pred);
      end
      if (res_bus.valid && res_bus.ready) begin
        got.lit_first       = res_bus.lit_first;
        got.lit_end         = res_bus.lit_end;
        got.lit_mask        = res_bus.lit_mask;
        got.refresh         = res_bus.refresh;
        got.power_toggle    = res_bus.power_toggle;
        got.bottom_occupied = res_bus.bottom_occupied;
        got.top_occupied    = res_bus.top_occupied;
        got.bottom_changed  = res_bus.bottom_changed;
        got.top_changed     = res_bus.top_changed;
        if (awaited_windows.size() == 0) begin
          $error("result beat arrived with no pass awaiting it");
          mismatches++;
        end else begin
          want = awaited_windows.pop_front();
          check_field("lit_first", want.lit_first, got.lit_first);
          check_field("lit_end", want.lit_end, got.lit_end);
          check_field("lit_mask", want.lit_mask, got.lit_mask);
          check_field("refresh", want.refresh, got.refresh);
          check_field("power_toggle", want.power_toggle, got.power_toggle);
          check_field("bottom_occupied", want.bottom_occupied, got.bottom_occupied);
          check_field("top_occupied", want.top_occupied, got.top_occupied);
          check_field("bottom_changed", want.bottom_changed, got.bottom_changed);
          check_field("top_changed", want.top_changed, got.top_changed);
        end
      end
    end
  end

  // The result side stalls now and then, except during the calm stretch.
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_bus.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is accepted,
  // with valid left high so that back-to-back beats need no extra assignment.
  task automatic drive_item(input in_item_t p, input bit typed, input out_item_t want);
    cfg_bus.valid <= 1'b0;
    while (!calm && $urandom_range(99) < 6) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid           <= 1'b1;
    in_bus.now_ms          <= p.now_ms;
    in_bus.bottom_range_mm <= p.bottom_range_mm;
    in_bus.top_range_mm    <= p.top_range_mm;
    in_bus.range_timeout   <= p.range_timeout;
    in_bus.force_bottom    <= p.force_bottom;
    in_bus.force_top       <= p.force_top;
    in_bus.first_segment   <= p.first_segment;
    in_bus.segment_end     <= p.segment_end;
    in_bus.lights_off      <= p.lights_off;
    row_typed              <= typed;
    row_want               <= want;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
    beats_offered++;
  endtask

  // Same convention as drive_item: valid stays high until the next pass beat lowers it.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
  endtask

  // Stop sending and let every awaited window come out, so that the two-stage pipe is
  // certainly empty before the registers change.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (awaited_windows.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic in_item_t pass_of(input logic [31:0] now, input logic [15:0] bot,
                                       input logic [15:0] top, input bit tmo, input bit fb,
                                       input bit ft, input logic [4:0] lo, input logic [5:0] hi,
                                       input bit dark);
    in_item_t p;
    p.now_ms          = now;
    p.bottom_range_mm = bot;
    p.top_range_mm    = top;
    p.range_timeout   = tmo;
    p.force_bottom    = fb;
    p.force_top       = ft;
    p.first_segment   = lo;
    p.segment_end     = hi;
    p.lights_off      = dark;
    return p;
  endfunction

  // A quiet result: only the window and its mask, every flag low.
  function automatic out_item_t idle_window(input int unsigned first, input int unsigned last,
                                            input logic [31:0] mask);
    out_item_t r;
    r           = '0;
    r.lit_first = LitW'(first);
    r.lit_end   = LitW'(last);
    r.lit_mask  = mask;
    return r;
  endfunction

  function automatic script_row_t pass_row(input in_item_t p, input bit typed = 1'b0,
                                           input out_item_t want = '0);
    script_row_t row;
    row.is_reg  = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.pass    = p;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  function automatic script_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] val);
    script_row_t row;
    row        = pass_row('0);
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Time between passes: mostly loop jitter, sometimes around the step delay, now and
  // then long enough for the hold time to run out.
  function automatic logic [31:0] next_gap();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(300, 0);
    if (pick < 90) return $urandom_range(2 * cf_step + 2, 1);
    if (pick < 97) return $urandom_range(3000, 250);
    return $urandom_range(32'(cf_hold) + 32'(cf_hold) / 2, 32'(cf_hold) / 2);
  endfunction

  // A pass whose readings put each sensor on the wanted side of its limit. With a limit
  // of zero no reading can count as occupied, so a manual trigger stands in for it.
  task automatic sensor_pass(input bit bocc, input bit tocc);
    in_item_t p;
    clock_ms += next_gap();
    if ($urandom_range(99) < 5) dark_now = !dark_now;
    p = pass_of(clock_ms, '0, '0, $urandom_range(99) < 3, $urandom_range(99) < 2,
                $urandom_range(99) < 2, FirstW'(span_lo), EndW'(span_hi), dark_now);
    if (bocc && cf_blim != 0) begin
      p.bottom_range_mm = RangeW'($urandom_range(cf_blim - 1, 0));
    end else begin
      p.bottom_range_mm = RangeW'($urandom_range(65535, cf_blim));
      p.force_bottom    = p.force_bottom | bocc;
    end
    if (tocc && cf_tlim != 0) begin
      p.top_range_mm = RangeW'($urandom_range(cf_tlim - 1, 0));
    end else begin
      p.top_range_mm = RangeW'($urandom_range(65535, cf_tlim));
      p.force_top    = p.force_top | tocc;
    end
    // Once in a while the span itself is garbage, inverted or beyond the strip.
    if ($urandom_range(99) < 4) begin
      p.first_segment = FirstW'($urandom);
      p.segment_end   = EndW'($urandom);
    end
    drive_item(p, 1'b0, '0);
  endtask

  task automatic sensor_leg(input bit bocc, input bit tocc, input int count);
    repeat (count) sensor_pass(bocc, tocc);
  endtask

  // One phase: program every register, the enable last since it resets the state, then
  // mostly people walking the stairs with a sprinkling of pure noise.
  task automatic run_phase(input logic [StepW-1:0] step, input logic [HoldW-1:0] hold,
                           input logic [LimitW-1:0] blim, input logic [LimitW-1:0] tlim,
                           input bit pf, input bit act, input int unsigned lo,
                           input int unsigned hi, input int count);
    int  goal;
    bit  from_bottom, exit_top;
    in_item_t p;
    settle();
    write_register(CfgStepDelay, step);
    write_register(CfgHoldTime, hold);
    write_register(CfgBottomLimit, blim);
    write_register(CfgTopLimit, tlim);
    write_register(CfgPowerFollow, pf);
    write_register(CfgActive, act);
    span_lo = lo;
    span_hi = hi;
    goal    = beats_offered + count;
    while (beats_offered < goal) begin
      if ($urandom_range(99) < 75) begin
        // Enter at one end, cross the middle, mostly leave at the other end, then a quiet
        // spell long enough at times for the lights to run out.
        from_bottom = 1'($urandom_range(1));
        exit_top    = ($urandom_range(99) < 80) ? from_bottom : !from_bottom;
        sensor_leg(from_bottom, !from_bottom, $urandom_range(4, 1));
        sensor_leg(1'b0, 1'b0, $urandom_range(6, 0));
        sensor_leg(!exit_top, exit_top, $urandom_range(4, 0));
        sensor_leg(1'b0, 1'b0, $urandom_range(40, 2));
      end else begin
        repeat ($urandom_range(5, 1)) begin
          if ($urandom_range(99) < 30) clock_ms = $urandom;
          else clock_ms += next_gap();
          p = pass_of(clock_ms, RangeW'($urandom), RangeW'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom), FirstW'($urandom), EndW'($urandom),
                      1'($urandom));
          drive_item(p, 1'b0, '0);
        end
      end
    end
  endtask

  initial begin
    in_bus.valid           = 1'b0;
    in_bus.now_ms          = '0;
    in_bus.bottom_range_mm = '0;
    in_bus.top_range_mm    = '0;
    in_bus.range_timeout   = 1'b0;
    in_bus.force_bottom    = 1'b0;
    in_bus.force_top       = 1'b0;
    in_bus.first_segment   = '0;
    in_bus.segment_end     = '0;
    in_bus.lights_off      = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
    cf_active              = 1'b0;
    cf_step                = StepDelayRst;
    cf_hold                = HoldTimeRst;
    cf_blim                = LimitRst;
    cf_tlim                = LimitRst;
    cf_pfollow             = 1'b0;
    clear_controller();

    // Disabled after reset: the stored window is empty, nothing else moves, and the
    // manual triggers latch quietly. Then the first enabled pass loads the full span.
    script.push_back(pass_row(pass_of(32'h0, 16'h0, 16'h0, 0, 1, 0, 0, 32, 0), 1,
                              idle_window(0, 0, 32'h0)));
    script.push_back(pass_row(pass_of(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 0, 1, 31, 63, 1),
                              1, idle_window(0, 0, 32'h0)));
    script.push_back(reg_row(CfgActive, 1));
    script.push_back(pass_row(pass_of(32'd0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32, 0), 1,
                              idle_window(0, 32, 32'hFFFF_FFFF)));
    // Swipe up from the bottom, re-aim from the top, both occupied, a pass inside the
    // scan interval, a timed-out scan, manual triggers alone and together, then run-out.
    script.push_back(pass_row(pass_of(32'd250, 16'd100, 16'hFFFF, 0, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd500, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd750, 16'hFFFF, 16'd100, 0, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd1000, 16'd100, 16'd100, 0, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd1100, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd1350, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd1600, 16'hFFFF, 16'hFFFF, 0, 0, 1, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd1850, 16'hFFFF, 16'hFFFF, 0, 1, 1, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd2100, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd40000, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'd40200, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32, 0)));
    // Extreme settings: fastest steps, shortest hold, top sensor blind, power follow on.
    script.push_back(reg_row(CfgStepDelay, 10));
    script.push_back(reg_row(CfgHoldTime, 10000));
    script.push_back(reg_row(CfgBottomLimit, 2000));
    script.push_back(reg_row(CfgTopLimit, 0));
    script.push_back(reg_row(CfgPowerFollow, 1));
    script.push_back(reg_row(CfgActive, 1));
    // An empty span primes an empty window, so the next swipe starts from dark with the
    // power off and asks for a toggle; the reading right at the limit counts as clear.
    script.push_back(pass_row(pass_of(32'd0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 10, 10, 1)));
    script.push_back(pass_row(pass_of(32'd250, 16'd1999, 16'hFFFF, 0, 0, 0, 3, 12, 1)));
    script.push_back(pass_row(pass_of(32'd260, 16'd1999, 16'hFFFF, 0, 0, 0, 3, 12, 1)));
    script.push_back(pass_row(pass_of(32'd300, 16'd2000, 16'd0, 0, 0, 0, 3, 12, 1)));
    script.push_back(pass_row(pass_of(32'd10600, 16'hFFFF, 16'hFFFF, 0, 0, 0, 3, 12, 0)));
    // Inverted span, a span end past the strip, and time wrapping through zero.
    script.push_back(pass_row(pass_of(32'd10700, 16'hFFFF, 16'hFFFF, 0, 0, 0, 31, 0, 0)));
    script.push_back(pass_row(pass_of(32'd10800, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 63, 0)));
    script.push_back(pass_row(pass_of(32'hFFFF_FF00, 16'd5, 16'hFFFF, 0, 0, 0, 0, 32, 0)));
    script.push_back(pass_row(pass_of(32'h0000_0010, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32, 0)));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[k]) begin
      if (script[k].is_reg) begin
        // A run of writes only waits for the block to go idle before its first write.
        if (!cfg_bus.valid) settle();
        write_register(script[k].reg_idx, script[k].reg_val);
      end else begin
        drive_item(script[k].pass, script[k].typed, script[k].want);
      end
    end

    // Random phases, each under its own settings; the second one runs without stalls.
    clock_ms = 32'd20000;
    run_phase(150, 30000, 900, 900, 0, 1, 0, 32, 300);
    calm = 1'b1;
    run_phase(10, 10000, 2000, 2000, 1, 1, 2, 30, 300);
    calm = 1'b0;
    clock_ms = 32'hFFFF_0000;
    run_phase(10000, 900000, 0, 0, 0, 1, 0, 16, 150);
    run_phase(StepW'($urandom_range(10000, 10)), HoldW'($urandom_range(900000, 10000)),
              LimitW'($urandom_range(2000, 0)), LimitW'($urandom_range(2000, 0)), 1, 0,
              4, 28, 100);
    run_phase(StepW'($urandom_range(10000, 10)), HoldW'($urandom_range(900000, 10000)),
              LimitW'($urandom_range(2000, 0)), LimitW'($urandom_range(2000, 0)), 1, 1,
              $urandom_range(31, 0), $urandom_range(32, 1), 350);
    run_phase(37, 10000, 1200, 600, 1, 1, 20, 8, 150);
    run_phase(StepW'($urandom_range(400, 10)), HoldW'($urandom_range(40000, 10000)), 900,
              900, 1, 1, 0, 32, 200);

    in_bus.valid <= 1'b0;
    while (awaited_windows.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a run that is still going at the time limit is reported as failed.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sslc_pkg.sv
rtl/sslc_if.sv
rtl/sslc_cfg.sv
rtl/sslc_pass.sv
rtl/staircase_swipe_light_controller_top.sv
rtl/sslc_checker.sv
tb/tb_staircase_swipe_light_controller_top.sv
